// ===== rtl/core/ps2dec_pkg.sv =====
// Package of shared types, codes and keymap tables for the PS/2 set-1 scancode decoder.
package ps2dec_pkg;

  localparam logic [7:0] SC_PREFIX_EXT = 8'hE0;
  localparam logic [6:0] SC_LSHIFT     = 7'd42;
  localparam logic [6:0] SC_RSHIFT     = 7'd54;
  localparam logic [6:0] SC_CAPS       = 7'd58;
  localparam logic [6:0] SC_UP         = 7'h48;
  localparam logic [6:0] SC_PGUP       = 7'h49;
  localparam logic [6:0] SC_DOWN       = 7'h50;
  localparam logic [6:0] SC_PGDN       = 7'h51;

  localparam logic [7:0] LED_CMD       = 8'hED;
  localparam logic [7:0] LED_CAPS      = 8'h04;
  localparam logic [7:0] LED_OFF       = 8'h00;

  localparam logic [7:0] NAV_UP        = 8'd0;
  localparam logic [7:0] NAV_PGUP      = 8'd1;
  localparam logic [7:0] NAV_DOWN      = 8'd2;
  localparam logic [7:0] NAV_PGDN      = 8'd3;

  localparam int unsigned MAP_LEN = 58;
  localparam int unsigned MAP_IW  = $clog2(MAP_LEN);

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_NAV  = 2'd1,
    KIND_CMD  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] value;
    logic       dbl;
  } job_t;

  localparam logic [7:0] PLAIN_MAP [0:MAP_LEN-1] = '{
    8'd0, 8'd27, "1", "2", "3", "4", "5", "6", "7", "8", "9", "0", "-", "=", 8'd8, 8'd9,
    "q", "w", "e", "r", "t", "y", "u", "i", "o", "p", "[", "]", 8'd10,
    8'd0, "a", "s", "d", "f", "g", "h", "j", "k", "l", ";", 8'd39, 8'd96, 8'd0, 8'd92,
    "z", "x", "c", "v", "b", "n", "m", ",", ".", "/", 8'd0, "*", 8'd0, " "
  };

  localparam logic [7:0] SHIFT_MAP [0:MAP_LEN-1] = '{
    8'd0, 8'd27, "!", "@", "#", "$", "%", "^", "&", "*", "(", ")", "_", "+", 8'd8, 8'd9,
    "Q", "W", "E", "R", "T", "Y", "U", "I", "O", "P", "{", "}", 8'd10,
    8'd0, "A", "S", "D", "F", "G", "H", "J", "K", "L", ":", 8'd34, 8'd126, 8'd0, 8'd124,
    "Z", "X", "C", "V", "B", "N", "M", "<", ">", "?", 8'd0, "*", 8'd0, " "
  };

endpackage

// ===== rtl/core/ps2_scancode_set1_decoder.sv =====
// Top level of the PS/2 set-1 scancode decoder.
// The block takes one scancode transaction per cycle while its two-entry job queue has room, and
// gives one result transaction per cycle while results are taken; a caps-lock press gives two
// results (LED command, then LED byte), which is what sets the sustained rate when such presses
// come back to back. A scancode that makes a job is written into the queue when it is accepted,
// and the job is then loaded from the queue into the output register, which presents its first
// result. The input stalls only when the queue is full, which happens when the output is
// held back or caps-lock presses arrive faster than the output can give their two results.
module ps2_scancode_set1_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] scancode
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] value
  output logic [1:0] out_tuser,  // [1:0] kind
  output logic       out_tlast   // last
);

  logic             q_full;
  logic             q_push;
  logic             q_pop;
  logic             q_empty;
  ps2dec_pkg::job_t job_in;
  ps2dec_pkg::job_t job_out;

  ps2dec_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_job_o   (job_in)
  );

  ps2dec_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (q_push),
    .job_i   (job_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .job_o   (job_out)
  );

  ps2dec_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty_i  (q_empty),
    .q_job_i    (job_out),
    .q_pop_o    (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== rtl/core/ps2dec_front.sv =====
// Front end: accepts scancodes, tracks prefix, shift and caps-lock state, and queues jobs.
module ps2dec_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,   // [7:0] scancode
  input  logic                q_full_i,
  output logic                q_push_o,
  output ps2dec_pkg::job_t    q_job_o
);

  logic ext_r, ext_nxt;
  logic lsh_r, lsh_nxt;
  logic rsh_r, rsh_nxt;
  logic caps_r, caps_nxt;
  logic accept;
  logic [6:0] code;
  logic [7:0] ch;
  logic push;
  ps2dec_pkg::job_t job;

  assign in_tready = !q_full_i;
  assign accept    = in_tvalid && in_tready;
  assign code      = in_tdata[6:0];

  always_comb begin
    ch = 8'd0;
    if (in_tdata < 8'(ps2dec_pkg::MAP_LEN)) begin
      if (lsh_r || rsh_r) begin
        ch = ps2dec_pkg::SHIFT_MAP[in_tdata[ps2dec_pkg::MAP_IW-1:0]];
      end else begin
        ch = ps2dec_pkg::PLAIN_MAP[in_tdata[ps2dec_pkg::MAP_IW-1:0]];
      end
    end
  end

  always_comb begin
    ext_nxt   = ext_r;
    lsh_nxt   = lsh_r;
    rsh_nxt   = rsh_r;
    caps_nxt  = caps_r;
    push      = 1'b0;
    job.kind  = ps2dec_pkg::KIND_CHAR;
    job.value = ch;
    job.dbl   = 1'b0;
    if (in_tdata == ps2dec_pkg::SC_PREFIX_EXT) begin
      ext_nxt = 1'b1;
    end else if (ext_r) begin
      ext_nxt  = 1'b0;
      job.kind = ps2dec_pkg::KIND_NAV;
      if (!in_tdata[7]) begin
        unique case (code)
          ps2dec_pkg::SC_UP: begin
            push      = 1'b1;
            job.value = ps2dec_pkg::NAV_UP;
          end
          ps2dec_pkg::SC_PGUP: begin
            push      = 1'b1;
            job.value = ps2dec_pkg::NAV_PGUP;
          end
          ps2dec_pkg::SC_DOWN: begin
            push      = 1'b1;
            job.value = ps2dec_pkg::NAV_DOWN;
          end
          ps2dec_pkg::SC_PGDN: begin
            push      = 1'b1;
            job.value = ps2dec_pkg::NAV_PGDN;
          end
          default: push = 1'b0;
        endcase
      end
    end else if (in_tdata[7]) begin
      if (code == ps2dec_pkg::SC_LSHIFT) lsh_nxt = 1'b0;
      if (code == ps2dec_pkg::SC_RSHIFT) rsh_nxt = 1'b0;
    end else if (code == ps2dec_pkg::SC_LSHIFT) begin
      lsh_nxt = 1'b1;
    end else if (code == ps2dec_pkg::SC_RSHIFT) begin
      rsh_nxt = 1'b1;
    end else if (code == ps2dec_pkg::SC_CAPS) begin
      caps_nxt  = !caps_r;
      push      = 1'b1;
      job.kind  = ps2dec_pkg::KIND_CMD;
      job.value = caps_nxt ? ps2dec_pkg::LED_CAPS : ps2dec_pkg::LED_OFF;
      job.dbl   = 1'b1;
    end else begin
      push = (ch != 8'd0);
    end
  end

  assign q_push_o = accept && push;
  assign q_job_o  = job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_r  <= 1'b0;
      lsh_r  <= 1'b0;
      rsh_r  <= 1'b0;
      caps_r <= 1'b0;
    end else if (accept) begin
      ext_r  <= ext_nxt;
      lsh_r  <= lsh_nxt;
      rsh_r  <= rsh_nxt;
      caps_r <= caps_nxt;
    end
  end

endmodule

// ===== rtl/core/ps2dec_queue.sv =====
// Short job queue between the front end and the back end.
module ps2dec_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_i,
  input  ps2dec_pkg::job_t  job_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output ps2dec_pkg::job_t  job_o
);

  ps2dec_pkg::job_t                 mem_r [0:ps2dec_pkg::QDEPTH-1];
  logic [ps2dec_pkg::QPTR_W-1:0]    wptr_r;
  logic [ps2dec_pkg::QPTR_W-1:0]    rptr_r;
  logic [ps2dec_pkg::QCNT_W-1:0]    cnt_r, cnt_nxt;
  logic                             do_push;
  logic                             do_pop;

  assign full_o  = (cnt_r == ps2dec_pkg::QCNT_W'(ps2dec_pkg::QDEPTH));
  assign empty_o = (cnt_r == '0);
  assign job_o   = mem_r[rptr_r];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + ps2dec_pkg::QCNT_W'(1);
    if (do_pop && !do_push) cnt_nxt = cnt_r - ps2dec_pkg::QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wptr_r] <= job_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) wptr_r <= wptr_r + ps2dec_pkg::QPTR_W'(1);
      if (do_pop)  rptr_r <= rptr_r + ps2dec_pkg::QPTR_W'(1);
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/core/ps2dec_back.sv =====
// Back end: turns queued jobs into result transactions through an output register.
module ps2dec_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty_i,
  input  ps2dec_pkg::job_t  q_job_i,
  output logic              q_pop_o,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,  // [7:0] value
  output logic [1:0]        out_tuser,  // [1:0] kind
  output logic              out_tlast   // last
);

  logic        vld_r;
  logic [1:0]  kind_r;
  logic [7:0]  val_r;
  logic        last_r;
  logic        second_r;
  logic [7:0]  second_val_r;
  logic        load;

  assign load    = !vld_r || out_tready;
  assign q_pop_o = load && !second_r && !q_empty_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= 1'b0;
      second_r <= 1'b0;
    end else if (load) begin
      if (second_r) begin
        vld_r    <= 1'b1;
        second_r <= 1'b0;
      end else if (!q_empty_i) begin
        vld_r    <= 1'b1;
        second_r <= q_job_i.dbl;
      end else begin
        vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (second_r) begin
        kind_r <= ps2dec_pkg::KIND_CMD;
        val_r  <= second_val_r;
        last_r <= 1'b1;
      end else if (q_job_i.dbl) begin
        kind_r       <= ps2dec_pkg::KIND_CMD;
        val_r        <= ps2dec_pkg::LED_CMD;
        last_r       <= 1'b0;
        second_val_r <= q_job_i.value;
      end else begin
        kind_r <= q_job_i.kind;
        val_r  <= q_job_i.value;
        last_r <= 1'b1;
      end
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = val_r;
  assign out_tuser  = kind_r;
  assign out_tlast  = last_r;

  a_second_follows_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    second_r |-> (vld_r && !last_r && val_r == ps2dec_pkg::LED_CMD))
    else $error("pending LED byte without a shown LED command");

  a_not_last_is_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && !last_r) |-> (kind_r == ps2dec_pkg::KIND_CMD))
    else $error("non-final result that is not a command byte");

  a_no_pop_while_second: assert property (@(posedge clk) disable iff (!rst_n)
    second_r |-> !q_pop_o)
    else $error("queue popped while the LED byte is still owed");

  a_led_byte_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && out_tready && !last_r) |=> (vld_r && last_r && kind_r == ps2dec_pkg::KIND_CMD))
    else $error("LED command not followed by its LED byte");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the PS/2 set-1 scancode decoder, with random idling on both sides.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned RANDOM_BYTES = 900;

  typedef struct packed {
    ps2dec_pkg::kind_t kind;
    logic [7:0]        value;
    logic              last;
  } key_event_t;

  localparam logic [7:0] KEYS_PLAIN [0:ps2dec_pkg::MAP_LEN-1] = '{
    8'd0, 8'd27, "1", "2", "3", "4", "5", "6", "7", "8", "9", "0", "-", "=", 8'd8, 8'd9,
    "q", "w", "e", "r", "t", "y", "u", "i", "o", "p", "[", "]", 8'd10,
    8'd0, "a", "s", "d", "f", "g", "h", "j", "k", "l", ";", 8'd39, 8'd96, 8'd0, 8'd92,
    "z", "x", "c", "v", "b", "n", "m", ",", ".", "/", 8'd0, "*", 8'd0, " "
  };

  localparam logic [7:0] KEYS_SHIFTED [0:ps2dec_pkg::MAP_LEN-1] = '{
    8'd0, 8'd27, "!", "@", "#", "$", "%", "^", "&", "*", "(", ")", "_", "+", 8'd8, 8'd9,
    "Q", "W", "E", "R", "T", "Y", "U", "I", "O", "P", "{", "}", 8'd10,
    8'd0, "A", "S", "D", "F", "G", "H", "J", "K", "L", ":", 8'd34, 8'd126, 8'd0, 8'd124,
    "Z", "X", "C", "V", "B", "N", "M", "<", ">", "?", 8'd0, "*", 8'd0, " "
  };

  localparam logic [7:0] OPENING_CODES [0:30] = '{
    8'h00, 8'h2B, 8'h39, 8'h3A, 8'h3A,
    8'h2A, 8'h10, 8'h36, 8'hAA, 8'h1E, 8'hB6, 8'h1E,
    8'hE0, 8'h48, 8'hE0, 8'h49, 8'hE0, 8'h50, 8'hE0, 8'h51,
    8'hE0, 8'hE0, 8'h48, 8'hE0, 8'hC8, 8'hE0, 8'h2A, 8'h10,
    8'h7F, 8'hFF, 8'h3A
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic [1:0] out_tuser;
  logic       out_tlast;

  logic [7:0] scancodes_to_send [$];
  key_event_t expected_events [$];
  int unsigned total_scancodes = 0;
  int unsigned sent_scancodes = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  logic       extended_seen = 1'b0;
  logic       left_shift_held = 1'b0;
  logic       right_shift_held = 1'b0;
  logic       caps_lock_on = 1'b0;

  int unsigned in_gap = 0;
  int unsigned out_wait = 0;
  logic        in_steady = 1'b0;
  logic        out_steady = 1'b0;

  ps2_scancode_set1_decoder u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #4 clk = ~clk;

  function automatic void push_event(input ps2dec_pkg::kind_t kind, input logic [7:0] value,
                                     input logic last);
    key_event_t ev;
    ev.kind = kind;
    ev.value = value;
    ev.last = last;
    expected_events.push_back(ev);
  endfunction

  function automatic void decode_scancode(input logic [7:0] sc);
    logic [7:0] ch;
    if (sc == ps2dec_pkg::SC_PREFIX_EXT) begin
      extended_seen = 1'b1;
    end else if (extended_seen) begin
      extended_seen = 1'b0;
      if (!sc[7]) begin
        case (sc[6:0])
          ps2dec_pkg::SC_UP:
            push_event(ps2dec_pkg::KIND_NAV, ps2dec_pkg::NAV_UP, 1'b1);
          ps2dec_pkg::SC_PGUP:
            push_event(ps2dec_pkg::KIND_NAV, ps2dec_pkg::NAV_PGUP, 1'b1);
          ps2dec_pkg::SC_DOWN:
            push_event(ps2dec_pkg::KIND_NAV, ps2dec_pkg::NAV_DOWN, 1'b1);
          ps2dec_pkg::SC_PGDN:
            push_event(ps2dec_pkg::KIND_NAV, ps2dec_pkg::NAV_PGDN, 1'b1);
          default: ;
        endcase
      end
    end else if (sc[7]) begin
      if (sc[6:0] == ps2dec_pkg::SC_LSHIFT) left_shift_held = 1'b0;
      if (sc[6:0] == ps2dec_pkg::SC_RSHIFT) right_shift_held = 1'b0;
    end else if (sc[6:0] == ps2dec_pkg::SC_LSHIFT) begin
      left_shift_held = 1'b1;
    end else if (sc[6:0] == ps2dec_pkg::SC_RSHIFT) begin
      right_shift_held = 1'b1;
    end else if (sc[6:0] == ps2dec_pkg::SC_CAPS) begin
      caps_lock_on = !caps_lock_on;
      push_event(ps2dec_pkg::KIND_CMD, ps2dec_pkg::LED_CMD, 1'b0);
      push_event(ps2dec_pkg::KIND_CMD,
                 caps_lock_on ? ps2dec_pkg::LED_CAPS : ps2dec_pkg::LED_OFF, 1'b1);
    end else if (sc < ps2dec_pkg::MAP_LEN) begin
      ch = (left_shift_held || right_shift_held) ? KEYS_SHIFTED[sc] : KEYS_PLAIN[sc];
      if (ch != 8'h00) push_event(ps2dec_pkg::KIND_CHAR, ch, 1'b1);
    end
  endfunction

  always @(posedge clk) begin : drive_scancodes
    logic holding;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        decode_scancode(in_tdata);
        sent_scancodes <= sent_scancodes + 1;
      end
      holding = in_tvalid && !in_tready;
      if (!holding) begin
        if (in_gap != 0) begin
          in_tvalid <= 1'b0;
          in_gap <= in_gap - 1;
        end else if (scancodes_to_send.size() != 0) begin
          in_tvalid <= 1'b1;
          in_tdata <= scancodes_to_send.pop_front();
          if ($urandom_range(0, 39) == 0) in_steady <= !in_steady;
          in_gap <= in_steady ? 0 : $urandom_range(0, 4);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_events
    key_event_t want;
    int unsigned wait_next;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_wait <= 0;
    end else begin
      wait_next = out_wait;
      if (out_tvalid && out_tready) begin
        if (expected_events.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, actual kind %0d value %02h last %0b",
                   $time, out_tuser, out_tdata, out_tlast);
          error_count = error_count + 1;
        end else begin
          want = expected_events.pop_front();
          if (out_tuser != want.kind) begin
            $display("%0t: kind mismatch, expected %0d, actual %0d", $time, want.kind, out_tuser);
            error_count = error_count + 1;
          end
          if (out_tdata != want.value) begin
            $display("%0t: value mismatch, expected %02h, actual %02h",
                     $time, want.value, out_tdata);
            error_count = error_count + 1;
          end
          if (out_tlast != want.last) begin
            $display("%0t: last mismatch, expected %0b, actual %0b", $time, want.last, out_tlast);
            error_count = error_count + 1;
          end
        end
        if ($urandom_range(0, 39) == 0) out_steady <= !out_steady;
        wait_next = out_steady ? 0 : $urandom_range(0, 4);
      end
      if (wait_next != 0) begin
        out_tready <= 1'b0;
        out_wait <= wait_next - 1;
      end else begin
        out_tready <= 1'b1;
        out_wait <= 0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d transactions still expected", $time, expected_events.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned pick;
    int unsigned taps;
    logic [7:0] code;
    foreach (OPENING_CODES[i]) scancodes_to_send.push_back(OPENING_CODES[i]);
    while (scancodes_to_send.size() < RANDOM_BYTES) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        code = 8'($urandom_range(0, ps2dec_pkg::MAP_LEN - 1));
        scancodes_to_send.push_back(code);
        if ($urandom_range(0, 1) == 1) scancodes_to_send.push_back(code | 8'h80);
      end else if (pick < 55) begin
        code = ($urandom_range(0, 1) == 1) ? {1'b0, ps2dec_pkg::SC_LSHIFT}
                                           : {1'b0, ps2dec_pkg::SC_RSHIFT};
        scancodes_to_send.push_back(code);
        taps = $urandom_range(1, 4);
        repeat (taps) begin
          scancodes_to_send.push_back(8'($urandom_range(0, ps2dec_pkg::MAP_LEN - 1)));
        end
        scancodes_to_send.push_back(code | 8'h80);
      end else if (pick < 70) begin
        scancodes_to_send.push_back(ps2dec_pkg::SC_PREFIX_EXT);
        case ($urandom_range(0, 5))
          0: code = {1'b0, ps2dec_pkg::SC_UP};
          1: code = {1'b0, ps2dec_pkg::SC_PGUP};
          2: code = {1'b0, ps2dec_pkg::SC_DOWN};
          3: code = {1'b0, ps2dec_pkg::SC_PGDN};
          4: code = {1'b1, ps2dec_pkg::SC_UP};
          default: code = 8'($urandom_range(0, 255));
        endcase
        scancodes_to_send.push_back(code);
      end else if (pick < 76) begin
        scancodes_to_send.push_back({1'b0, ps2dec_pkg::SC_CAPS});
        if ($urandom_range(0, 1) == 1) scancodes_to_send.push_back({1'b1, ps2dec_pkg::SC_CAPS});
      end else begin
        scancodes_to_send.push_back(8'($urandom_range(0, 255)));
      end
    end
    total_scancodes = scancodes_to_send.size();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (sent_scancodes < total_scancodes || expected_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0 && expected_events.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/ps2dec_pkg.sv
rtl/core/ps2dec_front.sv
rtl/core/ps2dec_queue.sv
rtl/core/ps2dec_back.sv
rtl/core/ps2_scancode_set1_decoder.sv
tb/testbench.sv
